### rtl/taa_pkg.sv
package taa_pkg;

  // Fixed field widths of the request, response and configuration data.
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned CFG_W   = 4;

  // Request commands.
  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  // Response status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_ALLOC = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [ADDR_W-1:0] address;
  } taa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  granted_address;
    status_e            status;
    logic [COUNT_W-1:0] used_count;
  } taa_rsp_t;

endpackage

### rtl/taa_stream_if.sv
interface taa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/taa_ram.sv
module taa_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; read data holds when not read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/trie_address_allocator.sv
// Allocate: a root check, then one full-mark memory access per tree level in the
// descent, the fallback descent and the climb that rewrites the marks. Release:
// a check of the leaf's pair, then the climb.
// One request is in work at a time; a finished response waits in an output register.
// After reset and after each active_bits write, a clearing pass over all 2^ADDR_BITS
// entries empties the mark memory before the first request is accepted.
module trie_address_allocator #(
  parameter int unsigned ADDR_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [taa_pkg::CFG_W-1:0] cfg_wdata_i,
  taa_stream_if.sink                req_if,
  taa_stream_if.source              rsp_if
);

  import taa_pkg::*;

  localparam int unsigned NW     = ADDR_BITS + 1;
  localparam int unsigned HW     = $clog2(ADDR_BITS + 1);
  localparam int unsigned PDEPTH = 2 ** ADDR_BITS;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_ROOT  = 8'b0000_0100,
    ST_DESC  = 8'b0000_1000,
    ST_FILL  = 8'b0001_0000,
    ST_REL   = 8'b0010_0000,
    ST_CLIMB = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [HW-1:0]        active_q, active_d;
  logic [NW-1:0]        occ_q, occ_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  cmd_e                 cmd_q, cmd_d;
  logic [NW-1:0]        node_q, node_d;
  logic [HW-1:0]        lev_q, lev_d;
  logic [NW-1:0]        cand_q, cand_d;
  logic [HW-1:0]        cand_lev_q, cand_lev_d;
  logic                 cand_vld_q, cand_vld_d;
  logic                 mark_q, mark_d;
  logic [ADDR_BITS-1:0] clr_q, clr_d;
  status_e              status_q, status_d;
  logic [ADDR_BITS-1:0] granted_q, granted_d;
  logic                 rsp_valid_q, rsp_valid_d;
  taa_rsp_t             rsp_q, rsp_d;

  // Mark memory: entry p holds the marks of nodes 2p (bit 0) and 2p+1 (bit 1).
  logic                 ram_we, ram_re;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [1:0]           ram_wdata, ram_rdata;

  taa_ram #(
    .WIDTH (2),
    .DEPTH (PDEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pool geometry at the current height.
  logic [NW-1:0]        base;
  logic [NW-1:0]        base_m1;
  logic [ADDR_BITS-1:0] mask;
  logic [31:0]          in_addr_ext;
  logic [ADDR_BITS-1:0] in_addr;
  logic [NW-1:0]        in_leaf;

  assign base        = NW'(1) << active_q;
  assign base_m1     = base - NW'(1);
  assign mask        = base_m1[ADDR_BITS-1:0];
  assign in_addr_ext = 32'(req_if.payload.address);
  assign in_addr     = in_addr_ext[ADDR_BITS-1:0] & mask;
  assign in_leaf     = base | NW'(in_addr);

  // Saturated height from a configuration write.
  int unsigned cfg_v;
  always_comb begin
    cfg_v = 32'(cfg_wdata_i);
    if (cfg_v < 1) begin
      cfg_v = 1;
    end
    if (cfg_v > ADDR_BITS) begin
      cfg_v = ADDR_BITS;
    end
  end

  // Per-level decode of the descent.
  logic [HW-1:0]        lev_m1;
  logic [ADDR_BITS-1:0] addr_shift;
  logic                 dir_bit;
  logic                 take_cand;
  logic [NW-1:0]        cand_n;
  logic [HW-1:0]        cand_l;
  logic                 cand_v;
  logic [NW-1:0]        child;
  logic [NW-1:0]        fill_child;
  logic [1:0]           new_pair;
  logic                 req_xfer;

  assign lev_m1     = lev_q - HW'(1);
  assign addr_shift = addr_q >> lev_m1;
  assign dir_bit    = addr_shift[0];
  assign take_cand  = !dir_bit && !ram_rdata[1];
  assign cand_n     = take_cand ? {node_q[NW-2:0], 1'b1} : cand_q;
  assign cand_l     = take_cand ? lev_m1 : cand_lev_q;
  assign cand_v     = take_cand || cand_vld_q;
  assign child      = {node_q[NW-2:0], dir_bit};
  assign fill_child = {node_q[NW-2:0], ram_rdata[0]};
  assign req_xfer   = req_if.valid && req_if.ready;

  // Pair after rewriting the mark of the current climb node.
  always_comb begin
    new_pair = ram_rdata;
    new_pair[node_q[0]] = mark_q;
  end

  // Response fields, masked to the port widths.
  function automatic taa_rsp_t rsp_next();
    taa_rsp_t    r;
    logic [31:0] g_ext;
    logic [31:0] o_ext;
    g_ext             = 32'(granted_q);
    o_ext             = 32'(occ_q);
    r.granted_address = g_ext[ADDR_W-1:0];
    r.status          = status_q;
    r.used_count      = o_ext[COUNT_W-1:0];
    return r;
  endfunction

  // Sequencer over the mark memory.
  logic [NW-1:0] leaf_sel;
  logic          leaf_hit;

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    occ_d       = occ_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    node_d      = node_q;
    lev_d       = lev_q;
    cand_d      = cand_q;
    cand_lev_d  = cand_lev_q;
    cand_vld_d  = cand_vld_q;
    mark_d      = mark_q;
    clr_d       = clr_q;
    status_d    = status_q;
    granted_d   = granted_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = 2'b00;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    leaf_sel    = node_q;
    leaf_hit    = 1'b0;

    if (rsp_valid_q && rsp_if.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + ADDR_BITS'(1);
        if (clr_q == ADDR_BITS'(PDEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_xfer) begin
          addr_d    = in_addr;
          cmd_d     = req_if.payload.command;
          granted_d = '0;
          status_d  = STATUS_OK;
          ram_re    = 1'b1;
          if (req_if.payload.command == CMD_RELEASE) begin
            node_d    = in_leaf;
            mark_d    = 1'b0;
            ram_raddr = in_leaf[NW-1:1];
            state_d   = ST_REL;
          end else begin
            ram_raddr = '0;
            state_d   = ST_ROOT;
          end
        end
      end

      ST_ROOT: begin
        if (ram_rdata[1]) begin
          status_d = STATUS_FULL;
          state_d  = ST_DONE;
        end else begin
          node_d     = NW'(1);
          lev_d      = active_q;
          cand_vld_d = 1'b0;
          ram_re     = 1'b1;
          ram_raddr  = ADDR_BITS'(1);
          state_d    = ST_DESC;
        end
      end

      ST_DESC: begin
        cand_d     = cand_n;
        cand_lev_d = cand_l;
        cand_vld_d = cand_v;
        if (ram_rdata[dir_bit]) begin
          // Blocked: fall back to the deepest free right branch, else the root.
          if (cand_v) begin
            leaf_sel = cand_n;
            lev_d    = cand_l;
          end else begin
            leaf_sel = NW'(1);
            lev_d    = active_q;
          end
          if (lev_d == '0) begin
            leaf_hit = 1'b1;
          end else begin
            node_d    = leaf_sel;
            ram_re    = 1'b1;
            ram_raddr = leaf_sel[ADDR_BITS-1:0];
            state_d   = ST_FILL;
          end
        end else begin
          leaf_sel = child;
          lev_d    = lev_m1;
          if (lev_m1 == '0) begin
            leaf_hit = 1'b1;
          end else begin
            node_d    = child;
            ram_re    = 1'b1;
            ram_raddr = child[ADDR_BITS-1:0];
          end
        end
      end

      ST_FILL: begin
        leaf_sel = fill_child;
        lev_d    = lev_m1;
        if (lev_m1 == '0) begin
          leaf_hit = 1'b1;
        end else begin
          node_d    = fill_child;
          ram_re    = 1'b1;
          ram_raddr = fill_child[ADDR_BITS-1:0];
        end
      end

      ST_REL: begin
        // The read data already holds the leaf's pair for the climb.
        if (!ram_rdata[node_q[0]]) begin
          status_d = STATUS_NOT_ALLOC;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_CLIMB;
        end
      end

      ST_CLIMB: begin
        ram_we    = 1'b1;
        ram_waddr = node_q[NW-1:1];
        ram_wdata = new_pair;
        if (node_q == NW'(1)) begin
          occ_d   = (cmd_q == CMD_RELEASE) ? occ_q - NW'(1) : occ_q + NW'(1);
          state_d = ST_DONE;
        end else begin
          node_d    = {1'b0, node_q[NW-1:1]};
          mark_d    = &new_pair;
          ram_re    = 1'b1;
          ram_raddr = ADDR_BITS'(node_q >> 2);
        end
      end

      ST_DONE: begin
        if (!rsp_valid_q || rsp_if.ready) begin
          rsp_valid_d = 1'b1;
          rsp_d       = rsp_next();
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase

    // Leaf found: mark it and climb from its pair.
    if (leaf_hit) begin
      granted_d = leaf_sel[ADDR_BITS-1:0] & mask;
      node_d    = leaf_sel;
      mark_d    = 1'b1;
      ram_re    = 1'b1;
      ram_raddr = leaf_sel[NW-1:1];
      state_d   = ST_CLIMB;
    end

    // A height change empties the pool.
    if (cfg_we_i) begin
      active_d = HW'(cfg_v);
      occ_d    = '0;
      clr_d    = '0;
      state_d  = ST_CLEAR;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      active_q    <= HW'(ADDR_BITS);
      occ_q       <= '0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      cand_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      occ_q       <= occ_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
      cand_vld_q  <= cand_vld_d;
    end
  end

  // Working payload.
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    cmd_q      <= cmd_d;
    node_q     <= node_d;
    lev_q      <= lev_d;
    cand_q     <= cand_d;
    cand_lev_q <= cand_lev_d;
    mark_q     <= mark_d;
    status_q   <= status_d;
    granted_q  <= granted_d;
    rsp_q      <= rsp_d;
  end

  assign req_if.ready   = (state_q == ST_IDLE);
  assign rsp_if.valid   = rsp_valid_q;
  assign rsp_if.payload = rsp_q;

endmodule

### rtl/taa_checker.sv
module taa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input taa_pkg::taa_rsp_t rsp_payload_i
);

  import taa_pkg::*;

  // A stalled response keeps its transfer pending with the same payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("response dropped or changed while stalled");

  // Failed allocations and releases never carry a granted address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.status != STATUS_OK |-> rsp_payload_i.granted_address == '0)
    else $error("granted address set on a failed operation");

  // Requests are never accepted back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted back to back");

  // A height change starts a clearing pass that holds off requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_ready_i)
    else $error("request accepted right after a configuration write");

endmodule

bind trie_address_allocator taa_checker u_taa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .req_valid_i   (req_if.valid),
  .req_ready_i   (req_if.ready),
  .rsp_valid_i   (rsp_if.valid),
  .rsp_ready_i   (rsp_if.ready),
  .rsp_payload_i (rsp_if.payload)
);
